// ===== hdl/trm_pkg.sv =====
// Package for the traffic rate meter: sizes, command codes and sequencer states.
// No dependencies; imported by traffic_rate_meter_core.
`timescale 1ns / 1ps

package trm_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = SLOT_W + 1;

    localparam int TIME_W  = 63;
    localparam int BYTES_W = 32;
    localparam int WIN_W   = 40;
    localparam int RATE_W  = 64;
    localparam int GAP_W   = 32;
    localparam int ECNT_W  = 7;
    localparam int PROD_W  = 112;

    // 1e9 * 2^16: bytes per nanosecond to bytes per second in Q48.16
    localparam logic [47:0] RATE_SCALE = 48'h3B9A_CA00_0000;
    localparam logic [GAP_W-1:0] JOIN_GAP_RESET = 32'd7500000;

    typedef enum logic [1:0] {
        CMD_ARRIVAL = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CMD,
        ST_MRG_RD,
        ST_MRG_WR,
        ST_CUR_A0,
        ST_CUR_A1,
        ST_CUR_D1,
        ST_PEAK,
        ST_Q_INIT,
        ST_W_ADDR,
        ST_W_DATA,
        ST_W_RATE,
        ST_AVG,
        ST_AVG_DONE,
        ST_DONE,
        ST_R_START,
        ST_R_MUL,
        ST_R_CHK,
        ST_R_DIV
    } state_t;

endpackage

// ===== hdl/traffic_rate_meter_core.sv =====
// Traffic rate meter: 64-entry history ring, shared rate unit (multiply, then divide).
// Depends on trm_pkg.
`timescale 1ns / 1ps
// Per transfer, with two or more entries held: one rate computation (current rate);
//   a merge first adds the bytes into the newest entry; a query also walks the
//   held entries and runs up to two more rate computations.
// Throughput: one transfer at a time; the shared 64-step restoring divider sets the pace.
// Reset: synchronous active-low aresetn clears control, counters and join gap (7500000);
//   history memory is not cleared, only entries counted as held are read.
module traffic_rate_meter_core
    import trm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [GAP_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_command,
    input  logic [TIME_W-1:0]   s_timestamp_ns,
    input  logic [BYTES_W-1:0]  s_byte_count,
    input  logic [ECNT_W-1:0]   s_entry_count,
    input  logic [WIN_W-1:0]    s_window_ns,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [RATE_W-1:0]   m_current_rate,
    output logic                m_rate_valid,
    output logic [RATE_W-1:0]   m_peak_rate,
    output logic [RATE_W-1:0]   m_total_bytes,
    output logic [RATE_W-1:0]   m_window_bytes,
    output logic [RATE_W-1:0]   m_window_rate,
    output logic                m_window_valid,
    output logic [RATE_W-1:0]   m_entry_avg_rate,
    output logic                m_entry_avg_valid
);

    // history memory
    logic [TIME_W-1:0]  mem_time [HISTORY_DEPTH];
    logic [BYTES_W-1:0] mem_bytes [HISTORY_DEPTH];
    logic [TIME_W-1:0]  rd_time_reg;
    logic [BYTES_W-1:0] rd_bytes_reg;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               wr_time_en, wr_bytes_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [TIME_W-1:0]  wr_time;
    logic [BYTES_W-1:0] wr_bytes;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [GAP_W-1:0]   join_gap_reg;
    cmd_t               cmd_reg, cmd_next;
    logic [TIME_W-1:0]  t_reg, t_next;
    logic [BYTES_W-1:0] nb_reg, nb_next;
    logic [ECNT_W-1:0]  n_reg, n_next;
    logic [WIN_W-1:0]   win_reg, win_next;

    logic [SLOT_W-1:0]  newest_reg, newest_next;
    logic [CNT_W-1:0]   held_reg, held_next;
    logic [TIME_W-1:0]  last_push_reg, last_push_next;
    logic [RATE_W-1:0]  peak_reg, peak_next;
    logic [RATE_W-1:0]  total_reg, total_next;

    logic [TIME_W-1:0]  time0_reg, time0_next;
    logic [BYTES_W-1:0] bytes0_reg, bytes0_next;
    logic [RATE_W-1:0]  cur_reg, cur_next;

    // query walk
    logic [CNT_W-1:0]   k_reg, k_next;
    logic               win_act_reg, win_act_next;
    logic               took_reg, took_next;
    logic [RATE_W-1:0]  wsum_reg, wsum_next;
    logic [RATE_W-1:0]  asum_reg, asum_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic [TIME_W-1:0]  avg_time_reg, avg_time_next;
    logic [RATE_W-1:0]  wrate_reg, wrate_next;
    logic               wvalid_reg, wvalid_next;
    logic [RATE_W-1:0]  arate_reg, arate_next;
    logic               avalid_reg, avalid_next;

    // shared rate unit
    logic [RATE_W-1:0]  r_bytes_reg, r_bytes_next;
    logic [TIME_W-1:0]  r_newer_reg, r_newer_next;
    logic [TIME_W-1:0]  r_older_reg, r_older_next;
    logic [TIME_W-1:0]  span_reg, span_next;
    logic [2:0]         mul_idx_reg, mul_idx_next;
    logic [63:0]        prod_reg, prod_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [63:0]        lo_reg, lo_next;
    logic [63:0]        q_reg, q_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic [RATE_W-1:0]  rate_res_reg, rate_res_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [RATE_W-1:0]  o_cur_reg, o_peak_reg, o_total_reg, o_wbytes_reg;
    logic [RATE_W-1:0]  o_wrate_reg, o_arate_reg;
    logic               o_rvalid_reg, o_wvalid_reg, o_avalid_reg;
    logic               out_load;

    // combinational helpers
    logic [TIME_W-1:0]  gap;
    logic [TIME_W:0]    span_diff;
    logic [TIME_W-1:0]  age;
    logic [CNT_W-1:0]   n_lim;
    logic [31:0]        a_half, c_half;
    logic [PROD_W-1:0]  prod_sh;
    logic [63:0]        trial;
    logic               trial_ge;
    logic [63:0]        q_shift;
    logic               held_ge2;

    assign held_ge2 = (held_reg >= CNT_W'(2));
    assign s_ready  = (state_reg == ST_IDLE);

    assign gap = (t_reg >= last_push_reg) ? (t_reg - last_push_reg) : (last_push_reg - t_reg);
    assign span_diff = {1'b0, r_newer_reg} - {1'b0, r_older_reg};
    assign age = t_reg - rd_time_reg;

    assign a_half  = mul_idx_reg[1] ? r_bytes_reg[63:32] : r_bytes_reg[31:0];
    assign c_half  = mul_idx_reg[0] ? {16'd0, RATE_SCALE[47:32]} : RATE_SCALE[31:0];

    // align the previous partial product by its index
    always_comb begin
        case (mul_idx_reg - 3'd1)
            3'd0:    prod_sh = {48'd0, prod_reg};
            3'd1,
            3'd2:    prod_sh = {16'd0, prod_reg, 32'd0};
            default: prod_sh = {prod_reg[47:0], 64'd0};
        endcase
    end

    assign trial    = {rem_reg, lo_reg[63]};
    assign trial_ge = (trial >= {1'b0, span_reg});
    assign q_shift  = {q_reg[62:0], trial_ge};

    // limit entry count to held entries, zero counts as one
    always_comb begin
        n_lim = (CNT_W'(n_reg) > held_reg) ? held_reg : CNT_W'(n_reg);
        if (n_lim == '0) begin
            n_lim = CNT_W'(1);
        end
    end

    // memory ports
    always_ff @(posedge aclk) begin
        if (wr_time_en) begin
            mem_time[wr_addr] <= wr_time;
        end
        if (wr_bytes_en) begin
            mem_bytes[wr_addr] <= wr_bytes;
        end
        if (rd_en) begin
            rd_time_reg  <= mem_time[rd_addr];
            rd_bytes_reg <= mem_bytes[rd_addr];
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            join_gap_reg <= JOIN_GAP_RESET;
        end else if (cfg_wr_en) begin
            join_gap_reg <= cfg_wr_data;
        end
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            newest_reg  <= '0;
            held_reg    <= '0;
            last_push_reg <= '0;
            peak_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            newest_reg  <= newest_next;
            held_reg    <= held_next;
            last_push_reg <= last_push_next;
            peak_reg    <= peak_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        t_reg         <= t_next;
        nb_reg        <= nb_next;
        n_reg         <= n_next;
        win_reg       <= win_next;
        time0_reg     <= time0_next;
        bytes0_reg    <= bytes0_next;
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        win_act_reg   <= win_act_next;
        took_reg      <= took_next;
        wsum_reg      <= wsum_next;
        asum_reg      <= asum_next;
        last_time_reg <= last_time_next;
        avg_time_reg  <= avg_time_next;
        wrate_reg     <= wrate_next;
        wvalid_reg    <= wvalid_next;
        arate_reg     <= arate_next;
        avalid_reg    <= avalid_next;
        r_bytes_reg   <= r_bytes_next;
        r_newer_reg   <= r_newer_next;
        r_older_reg   <= r_older_next;
        span_reg      <= span_next;
        mul_idx_reg   <= mul_idx_next;
        prod_reg      <= prod_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        lo_reg        <= lo_next;
        q_reg         <= q_next;
        div_cnt_reg   <= div_cnt_next;
        rate_res_reg  <= rate_res_next;
        if (out_load) begin
            o_cur_reg    <= cur_reg;
            o_rvalid_reg <= held_ge2;
            o_peak_reg   <= peak_reg;
            o_total_reg  <= total_reg;
            o_wbytes_reg <= wsum_reg;
            o_wrate_reg  <= wrate_reg;
            o_wvalid_reg <= wvalid_reg;
            o_arate_reg  <= arate_reg;
            o_avalid_reg <= avalid_reg;
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd_next   = cmd_reg;
        t_next     = t_reg;
        nb_next    = nb_reg;
        n_next     = n_reg;
        win_next   = win_reg;
        newest_next    = newest_reg;
        held_next      = held_reg;
        last_push_next = last_push_reg;
        peak_next      = peak_reg;
        total_next     = total_reg;
        time0_next     = time0_reg;
        bytes0_next    = bytes0_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        win_act_next   = win_act_reg;
        took_next      = took_reg;
        wsum_next      = wsum_reg;
        asum_next      = asum_reg;
        last_time_next = last_time_reg;
        avg_time_next  = avg_time_reg;
        wrate_next     = wrate_reg;
        wvalid_next    = wvalid_reg;
        arate_next     = arate_reg;
        avalid_next    = avalid_reg;
        r_bytes_next   = r_bytes_reg;
        r_newer_next   = r_newer_reg;
        r_older_next   = r_older_reg;
        span_next      = span_reg;
        mul_idx_next   = mul_idx_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        lo_next        = lo_reg;
        q_next         = q_reg;
        div_cnt_next   = div_cnt_reg;
        rate_res_next  = rate_res_reg;
        m_valid_next   = m_valid_reg;
        out_load       = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = newest_reg;
        wr_time_en     = 1'b0;
        wr_bytes_en    = 1'b0;
        wr_addr        = newest_reg;
        wr_time        = t_reg;
        wr_bytes       = nb_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next    = cmd_t'(s_command);
                    t_next      = s_timestamp_ns;
                    nb_next     = s_byte_count;
                    n_next      = s_entry_count;
                    win_next    = s_window_ns;
                    wsum_next   = '0;
                    wrate_next  = '0;
                    wvalid_next = 1'b0;
                    arate_next  = '0;
                    avalid_next = 1'b0;
                    state_next  = ST_CMD;
                end
            end
            ST_CMD: begin
                state_next = ST_CUR_A0;
                case (cmd_reg)
                    CMD_ARRIVAL: begin
                        total_next = total_reg + RATE_W'(nb_reg);
                        if (held_reg != '0 && gap < TIME_W'(join_gap_reg)) begin
                            state_next = ST_MRG_RD;
                        end else begin
                            // push a new entry
                            newest_next    = newest_reg + SLOT_W'(1);
                            wr_addr        = newest_reg + SLOT_W'(1);
                            wr_time_en     = 1'b1;
                            wr_bytes_en    = 1'b1;
                            last_push_next = t_reg;
                            if (held_reg < CNT_W'(HISTORY_DEPTH)) begin
                                held_next = held_reg + CNT_W'(1);
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        held_next  = '0;
                        total_next = '0;
                        peak_next  = '0;
                    end
                    default: ;
                endcase
            end
            ST_MRG_RD: begin
                rd_en      = 1'b1;
                state_next = ST_MRG_WR;
            end
            ST_MRG_WR: begin
                wr_bytes_en = 1'b1;
                wr_bytes    = rd_bytes_reg + nb_reg;
                state_next  = ST_CUR_A0;
            end
            ST_CUR_A0: begin
                rd_en = 1'b1;
                state_next = held_ge2 ? ST_CUR_A1 : ST_PEAK;
            end
            ST_CUR_A1: begin
                time0_next  = rd_time_reg;
                bytes0_next = rd_bytes_reg;
                rd_en       = 1'b1;
                rd_addr     = newest_reg - SLOT_W'(1);
                state_next  = ST_CUR_D1;
            end
            ST_CUR_D1: begin
                r_bytes_next = RATE_W'(bytes0_reg);
                r_newer_next = time0_reg;
                r_older_next = rd_time_reg;
                ret_next     = ST_PEAK;
                state_next   = ST_R_START;
            end
            ST_PEAK: begin
                cur_next = held_ge2 ? rate_res_reg : '0;
                if (cmd_reg == CMD_ARRIVAL && held_ge2 && rate_res_reg > peak_reg) begin
                    peak_next = rate_res_reg;
                end
                state_next = (cmd_reg == CMD_QUERY && held_ge2) ? ST_Q_INIT : ST_DONE;
            end
            ST_Q_INIT: begin
                k_next         = CNT_W'(1);
                win_act_next   = 1'b1;
                took_next      = 1'b0;
                asum_next      = '0;
                last_time_next = time0_reg;
                avg_time_next  = time0_reg;
                n_next         = ECNT_W'(n_lim);
                wvalid_next    = 1'b1;
                state_next     = ST_W_ADDR;
            end
            ST_W_ADDR: begin
                if (k_reg >= held_reg || (!win_act_reg && k_reg >= CNT_W'(n_reg))) begin
                    state_next = ST_W_RATE;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = newest_reg - k_reg[SLOT_W-1:0];
                    state_next = ST_W_DATA;
                end
            end
            ST_W_DATA: begin
                // window: stop at the first entry older than the window
                if (win_act_reg) begin
                    if (t_reg >= rd_time_reg && age > TIME_W'(win_reg)) begin
                        win_act_next = 1'b0;
                    end else begin
                        took_next      = 1'b1;
                        wsum_next      = wsum_reg + RATE_W'(rd_bytes_reg);
                        last_time_next = rd_time_reg;
                    end
                end
                if (k_reg < CNT_W'(n_reg)) begin
                    asum_next = asum_reg + RATE_W'(rd_bytes_reg);
                end
                if (k_reg == CNT_W'(n_reg) - CNT_W'(1)) begin
                    avg_time_next = rd_time_reg;
                end
                k_next     = k_reg + CNT_W'(1);
                state_next = ST_W_ADDR;
            end
            ST_W_RATE: begin
                if (took_reg) begin
                    r_bytes_next = wsum_reg;
                    r_newer_next = time0_reg;
                    r_older_next = last_time_reg;
                    ret_next     = ST_AVG;
                    state_next   = ST_R_START;
                end else begin
                    wrate_next = cur_reg;
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (took_reg) begin
                    wrate_next = rate_res_reg;
                end
                if (time0_reg > avg_time_reg) begin
                    avalid_next  = 1'b1;
                    r_bytes_next = asum_reg;
                    r_newer_next = time0_reg;
                    r_older_next = avg_time_reg;
                    ret_next     = ST_AVG_DONE;
                    state_next   = ST_R_START;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_AVG_DONE: begin
                arate_next = rate_res_reg;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_R_START: begin
                span_next    = span_diff[TIME_W-1:0];
                mul_idx_next = '0;
                acc_next     = '0;
                if (span_diff[TIME_W]) begin
                    rate_res_next = '0;
                    state_next    = ret_reg;
                end else if (span_diff[TIME_W-1:0] == '0) begin
                    rate_res_next = (r_bytes_reg != '0) ? '1 : '0;
                    state_next    = ret_reg;
                end else begin
                    state_next = ST_R_MUL;
                end
            end
            ST_R_MUL: begin
                // one 32x32 partial product per cycle, accumulate the previous one
                prod_next    = a_half * c_half;
                mul_idx_next = mul_idx_reg + 3'd1;
                if (mul_idx_reg != 3'd0) begin
                    acc_next = acc_reg + prod_sh;
                end
                if (mul_idx_reg == 3'd4) begin
                    state_next = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                rem_next     = TIME_W'(acc_reg[PROD_W-1:64]);
                lo_next      = acc_reg[63:0];
                q_next       = '0;
                div_cnt_next = '0;
                if ({15'd0, acc_reg[PROD_W-1:64]} >= span_reg) begin
                    rate_res_next = '1;
                    state_next    = ret_reg;
                end else begin
                    state_next = ST_R_DIV;
                end
            end
            ST_R_DIV: begin
                // restoring division, one quotient bit per cycle
                rem_next     = trial_ge ? TIME_W'(trial - {1'b0, span_reg}) : trial[TIME_W-1:0];
                lo_next      = {lo_reg[62:0], 1'b0};
                q_next       = q_shift;
                div_cnt_next = div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd63) begin
                    rate_res_next = q_shift;
                    state_next    = ret_reg;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_current_rate    = o_cur_reg;
    assign m_rate_valid      = o_rvalid_reg;
    assign m_peak_rate       = o_peak_reg;
    assign m_total_bytes     = o_total_reg;
    assign m_window_bytes    = o_wbytes_reg;
    assign m_window_rate     = o_wrate_reg;
    assign m_window_valid    = o_wvalid_reg;
    assign m_entry_avg_rate  = o_arate_reg;
    assign m_entry_avg_valid = o_avalid_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(HISTORY_DEPTH))
        else $error("history count exceeds depth");

    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_R_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

    a_rate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_rate_valid) |-> (m_current_rate == '0))
        else $error("current rate set without two entries");

    a_window_needs_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_window_valid || m_entry_avg_valid)) |-> m_rate_valid)
        else $error("query result valid with fewer than two entries");

    a_ready_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && s_ready))
        else $error("result load did not return to idle");
`endif

endmodule

// ===== verif/traffic_rate_meter_core_tb.sv =====
// Testbench for traffic_rate_meter_core: directed table, then random arrivals, queries and clears
// under several join gaps, checked against an in-bench rate predictor. Depends on trm_pkg.
`timescale 1ns / 1ps

module traffic_rate_meter_core_tb;
    import trm_pkg::*;

    localparam int          CYCLE_LIMIT = 3000000;
    localparam int          RANDOM_ITEMS = 950;
    localparam logic [63:0] RATE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] current_rate;
        logic        rate_valid;
        logic [63:0] peak_rate;
        logic [63:0] total_bytes;
        logic [63:0] window_bytes;
        logic [63:0] window_rate;
        logic        window_valid;
        logic [63:0] entry_avg_rate;
        logic        entry_avg_valid;
    } meter_result_t;

    typedef struct {
        cmd_t          cmd;
        logic [62:0]   ts;
        logic [31:0]   nbytes;
        logic [6:0]    ecnt;
        logic [39:0]   win;
        bit            known;
        meter_result_t known_res;
    } meter_op_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en;
    logic [GAP_W-1:0]    cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_command;
    logic [TIME_W-1:0]   s_timestamp_ns;
    logic [BYTES_W-1:0]  s_byte_count;
    logic [ECNT_W-1:0]   s_entry_count;
    logic [WIN_W-1:0]    s_window_ns;
    logic                m_valid;
    logic                m_ready;
    logic [RATE_W-1:0]   m_current_rate;
    logic                m_rate_valid;
    logic [RATE_W-1:0]   m_peak_rate;
    logic [RATE_W-1:0]   m_total_bytes;
    logic [RATE_W-1:0]   m_window_bytes;
    logic [RATE_W-1:0]   m_window_rate;
    logic                m_window_valid;
    logic [RATE_W-1:0]   m_entry_avg_rate;
    logic                m_entry_avg_valid;

    traffic_rate_meter_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_timestamp_ns    (s_timestamp_ns),
        .s_byte_count      (s_byte_count),
        .s_entry_count     (s_entry_count),
        .s_window_ns       (s_window_ns),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_current_rate    (m_current_rate),
        .m_rate_valid      (m_rate_valid),
        .m_peak_rate       (m_peak_rate),
        .m_total_bytes     (m_total_bytes),
        .m_window_bytes    (m_window_bytes),
        .m_window_rate     (m_window_rate),
        .m_window_valid    (m_window_valid),
        .m_entry_avg_rate  (m_entry_avg_rate),
        .m_entry_avg_valid (m_entry_avg_valid)
    );

    // Free-running clock, 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Predictor state: history ring, counters and join gap
    logic [62:0]   hist_time [HISTORY_DEPTH];
    logic [31:0]   hist_bytes [HISTORY_DEPTH];
    logic [5:0]    head_slot;
    int unsigned   held_count;
    logic [62:0]   last_push_ns;
    logic [63:0]   peak_seen;
    logic [63:0]   bytes_sum;
    logic [31:0]   join_gap;

    meter_result_t expected_results[$];
    meter_op_t     directed_ops[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;

    // Q48.16 bytes per second over a span, saturating
    function automatic logic [63:0] span_rate(logic [63:0] b, logic [62:0] newer,
                                              logic [62:0] older);
        logic [127:0] prod;
        logic [127:0] quo;
        logic [63:0]  span;
        if (newer < older) return 64'd0;
        span = {1'b0, newer} - {1'b0, older};
        if (span == 0) return (b != 0) ? RATE_MAX : 64'd0;
        prod = {64'd0, b} * {80'd0, RATE_SCALE};
        if (prod[127:64] >= span) return RATE_MAX;
        quo = prod / {64'd0, span};
        return quo[63:0];
    endfunction

    function automatic logic [5:0] slot_at(int unsigned age);
        return head_slot - 6'(age % HISTORY_DEPTH);
    endfunction

    function automatic logic [63:0] newest_rate();
        if (held_count < 2) return 64'd0;
        return span_rate({32'd0, hist_bytes[slot_at(0)]}, hist_time[slot_at(0)],
                         hist_time[slot_at(1)]);
    endfunction

    // Advance the predictor by one accepted transfer
    function automatic meter_result_t predict_meter(meter_op_t op);
        meter_result_t r;
        logic [62:0]   gap;
        logic [63:0]   cur;
        int unsigned   last_k;
        int unsigned   n;
        logic [63:0]   avg_sum;
        logic [62:0]   et;
        r = '0;
        if (op.cmd == CMD_ARRIVAL) begin
            gap = (op.ts >= last_push_ns) ? op.ts - last_push_ns : last_push_ns - op.ts;
            bytes_sum = bytes_sum + {32'd0, op.nbytes};
            if (held_count > 0 && {1'b0, gap} < {32'd0, join_gap}) begin
                hist_bytes[head_slot] = hist_bytes[head_slot] + op.nbytes;
            end else begin
                head_slot = head_slot + 6'd1;
                hist_time[head_slot] = op.ts;
                hist_bytes[head_slot] = op.nbytes;
                if (held_count < HISTORY_DEPTH) held_count++;
                last_push_ns = op.ts;
            end
            if (held_count >= 2) begin
                cur = newest_rate();
                if (cur > peak_seen) peak_seen = cur;
            end
        end else if (op.cmd == CMD_CLEAR) begin
            held_count = 0;
            bytes_sum = 0;
            peak_seen = 0;
        end
        cur = newest_rate();
        if (op.cmd == CMD_QUERY && held_count >= 2) begin
            last_k = 0;
            for (int unsigned k = 1; k < held_count; k++) begin
                et = hist_time[slot_at(k)];
                if (op.ts >= et && {1'b0, op.ts - et} > {24'd0, op.win}) break;
                last_k = k;
                r.window_bytes = r.window_bytes + {32'd0, hist_bytes[slot_at(k)]};
            end
            r.window_valid = 1'b1;
            if (last_k < 1)
                r.window_rate = cur;
            else
                r.window_rate = span_rate(r.window_bytes, hist_time[slot_at(0)],
                                          hist_time[slot_at(last_k)]);
            n = op.ecnt;
            if (n > held_count) n = held_count;
            if (n < 1) n = 1;
            avg_sum = 0;
            for (int unsigned k = 1; k < n; k++)
                avg_sum = avg_sum + {32'd0, hist_bytes[slot_at(k)]};
            if (hist_time[slot_at(0)] > hist_time[slot_at(n - 1)]) begin
                r.entry_avg_valid = 1'b1;
                r.entry_avg_rate = span_rate(avg_sum, hist_time[slot_at(0)],
                                             hist_time[slot_at(n - 1)]);
            end
        end
        r.current_rate = cur;
        r.rate_valid = (held_count >= 2);
        r.peak_rate = peak_seen;
        r.total_bytes = bytes_sum;
        return r;
    endfunction

    function automatic meter_op_t make_op(cmd_t c, logic [62:0] ts, logic [31:0] nb,
                                          logic [6:0] ec, logic [39:0] w);
        meter_op_t op;
        op.cmd = c;
        op.ts = ts;
        op.nbytes = nb;
        op.ecnt = ec;
        op.win = w;
        op.known = 0;
        op.known_res = '0;
        return op;
    endfunction

    // Drive one transfer, then record its expected result at the accepting edge
    task automatic send_op(meter_op_t op);
        int            idle;
        meter_result_t r;
        idle = $urandom_range(0, 12);
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= op.cmd;
        s_timestamp_ns <= op.ts;
        s_byte_count <= op.nbytes;
        s_entry_count <= op.ecnt;
        s_window_ns <= op.win;
        do @(posedge aclk); while (!s_ready);
        r = predict_meter(op);
        expected_results.push_back(op.known ? op.known_res : r);
    endtask

    // Write the join gap once the block has drained
    task automatic write_join_gap(logic [31:0] value);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        join_gap = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Result side: random stalls, compare against the oldest expectation
    initial begin
        meter_result_t e;
        int            stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(0, 12);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (expected_results.size() == 0) begin
                $display("%0t: result transfer with nothing expected", $realtime);
                mismatch_count++;
            end else begin
                e = expected_results.pop_front();
                check_field("current_rate", e.current_rate, m_current_rate);
                check_field("rate_valid", 64'(e.rate_valid), 64'(m_rate_valid));
                check_field("peak_rate", e.peak_rate, m_peak_rate);
                check_field("total_bytes", e.total_bytes, m_total_bytes);
                check_field("window_bytes", e.window_bytes, m_window_bytes);
                check_field("window_rate", e.window_rate, m_window_rate);
                check_field("window_valid", 64'(e.window_valid), 64'(m_window_valid));
                check_field("entry_avg_rate", e.entry_avg_rate, m_entry_avg_rate);
                check_field("entry_avg_valid", 64'(e.entry_avg_valid),
                            64'(m_entry_avg_valid));
            end
        end
    end

    // Cycle limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // Stimulus
    initial begin
        meter_op_t      op;
        logic [62:0]    now_ns;
        logic [31:0]    gap_plan [5];
        int unsigned    sel;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_command = CMD_ARRIVAL;
        s_timestamp_ns = '0;
        s_byte_count = '0;
        s_entry_count = '0;
        s_window_ns = '0;
        head_slot = 0;
        held_count = 0;
        last_push_ns = 0;
        peak_seen = 0;
        bytes_sum = 0;
        join_gap = JOIN_GAP_RESET;

        // Directed table: reset state, extremes, merge, wrap, clear, backward time
        op = make_op(CMD_QUERY, 63'd0, 32'd0, 7'd0, 40'd0);
        op.known = 1;
        directed_ops.push_back(op);
        op = make_op(CMD_ARRIVAL, 63'd1000, 32'd100, 7'd0, 40'd0);
        op.known = 1;
        op.known_res.total_bytes = 64'd100;
        directed_ops.push_back(op);
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd7501000, 32'd0, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd7501001, 32'hFFFF_FFFF, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd7501002, 32'hFFFF_FFFF, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd20000000, 32'd1, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd60000000, 32'd1500, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_QUERY, 63'd60000000, 32'd0, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_QUERY, 63'd70000000, 32'd0, 7'd64,
                                       40'hFF_FFFF_FFFF));
        directed_ops.push_back(make_op(CMD_QUERY, 63'd5, 32'd0, 7'd3, 40'd0));
        directed_ops.push_back(make_op(CMD_QUERY, TIME_MAX, 32'hFFFF_FFFF, 7'd2,
                                       40'd40000000));
        directed_ops.push_back(make_op(CMD_QUERY, 63'd65000000, 32'd0, 7'd1, 40'd45000000));
        op = make_op(CMD_CLEAR, 63'd0, 32'd0, 7'd0, 40'd0);
        op.known = 1;
        directed_ops.push_back(op);
        op = make_op(CMD_QUERY, 63'd80000000, 32'd0, 7'd64, 40'hFF_FFFF_FFFF);
        op.known = 1;
        directed_ops.push_back(op);
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd100000000, 32'd64, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, TIME_MAX, 32'hFFFF_FFFF, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd0, 32'd500, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_QUERY, 63'd0, 32'd0, 7'd64, 40'd0));
        directed_ops.push_back(make_op(CMD_ARRIVAL, 63'd30000000, 32'd9000, 7'd0, 40'd0));
        directed_ops.push_back(make_op(CMD_QUERY, TIME_MAX, 32'd0, 7'd2, 40'hFF_FFFF_FFFF));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_ops[i]) send_op(directed_ops[i]);

        // Random phases, one join gap each
        gap_plan[0] = 32'd0;
        gap_plan[1] = 32'hFFFF_FFFF;
        gap_plan[2] = JOIN_GAP_RESET;
        gap_plan[3] = $urandom();
        gap_plan[4] = 32'd1000;
        now_ns = 63'd1000;
        for (int p = 0; p < 5; p++) begin
            write_join_gap(gap_plan[p]);
            for (int i = 0; i < RANDOM_ITEMS / 5; i++) begin
                // Advance time: repeats, small, around the gap, large, rarely backward
                sel = $urandom_range(0, 99);
                if (sel < 10)
                    now_ns = now_ns;
                else if (sel < 35)
                    now_ns = now_ns + 63'($urandom_range(0, 2000));
                else if (sel < 65)
                    now_ns = now_ns + 63'($urandom_range(0, 2 * 7500000));
                else if (sel < 85)
                    now_ns = now_ns + 63'($urandom());
                else if (sel < 93)
                    now_ns = now_ns + {23'd0, 8'($urandom()), 32'($urandom())};
                else if (sel < 97)
                    now_ns = now_ns - 63'($urandom_range(0, 100000000));
                else
                    now_ns = {31'($urandom()), 32'($urandom())};

                sel = $urandom_range(0, 99);
                if (sel < 62) begin
                    op = make_op(CMD_ARRIVAL, now_ns, $urandom(), 7'd0, 40'd0);
                    case ($urandom_range(0, 9))
                        0: op.nbytes = 32'd0;
                        1: op.nbytes = 32'hFFFF_FFFF;
                        2, 3, 4: op.nbytes = $urandom_range(40, 1500);
                        default: ;
                    endcase
                end else if (sel < 96) begin
                    op = make_op(CMD_QUERY, now_ns + 63'($urandom_range(0, 50000000)),
                                 $urandom(), 7'($urandom_range(0, 64)),
                                 {8'($urandom()), 32'($urandom())});
                    case ($urandom_range(0, 5))
                        0: op.win = 40'($urandom_range(0, 100000000));
                        1: op.win = 40'($urandom());
                        2: op.ts = now_ns - 63'($urandom_range(0, 100000000));
                        default: ;
                    endcase
                end else begin
                    op = make_op(CMD_CLEAR, {31'($urandom()), 32'($urandom())}, $urandom(),
                                 7'($urandom_range(0, 64)), {8'($urandom()), 32'($urandom())});
                end
                send_op(op);
            end
        end

        // Drain, then allow for the longest query before judging
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
